@@ rtl/core/owts_pkg.sv @@
// Shared codes, result layout and CRC-8 tables for the 1-wire sensor sequencer.
`default_nettype none

package owts_pkg;

   // Request operation codes
   localparam logic [1:0] OP_ROM_CHECK = 2'd0;
   localparam logic [1:0] OP_TEMP_READ = 2'd1;
   localparam logic [1:0] OP_RESPONSE  = 2'd2;
   // Spare code, dropped without a result
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   // Result kinds
   localparam logic [2:0] KIND_RESET  = 3'd0;
   localparam logic [2:0] KIND_WRITE  = 3'd1;
   localparam logic [2:0] KIND_READ   = 3'd2;
   localparam logic [2:0] KIND_WAIT   = 3'd3;
   localparam logic [2:0] KIND_REPORT = 3'd4;

   // Report status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NODEV = 2'd1;
   localparam logic [1:0] STATUS_CRC   = 2'd2;

   // Bus command bytes
   localparam logic [7:0] CMD_READ_ROM     = 8'h33;
   localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
   localparam logic [7:0] CMD_CONVERT      = 8'h44;
   localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

   // Bytes read per job; the last one is the CRC byte
   localparam logic [3:0] ROM_BYTES  = 4'd8;
   localparam logic [3:0] TEMP_BYTES = 4'd9;
   // Bytes kept: all ROM bytes but the CRC byte, which is taken straight from the bus
   localparam int STORED_BYTES = 7;
   localparam int STORE_IDX_W  = $clog2(STORED_BYTES);

   // Configuration registers
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_SETTLE_WAIT = 2'd0;
   localparam logic [1:0] REG_SHORT_WAIT  = 2'd1;
   localparam logic [1:0] REG_CONV_WAIT   = 2'd2;
   localparam logic [9:0]  SETTLE_WAIT_RESET = 10'd10;
   localparam logic [9:0]  SHORT_WAIT_RESET  = 10'd5;
   localparam logic [11:0] CONV_WAIT_RESET   = 12'd800;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         write_data;
      logic [11:0]        wait_ms;
      logic [1:0]         status;
      logic signed [11:0] temperature;
      logic [63:0]        rom_code;
   } rsp_type;

   function automatic logic [7:0] crc_lo_nib(input logic [3:0] n);
      logic [7:0] r;
      case (n)
         4'h0: r = 8'h00;  4'h1: r = 8'h5E;  4'h2: r = 8'hBC;  4'h3: r = 8'hE2;
         4'h4: r = 8'h61;  4'h5: r = 8'h3F;  4'h6: r = 8'hDD;  4'h7: r = 8'h83;
         4'h8: r = 8'hC2;  4'h9: r = 8'h9C;  4'hA: r = 8'h7E;  4'hB: r = 8'h20;
         4'hC: r = 8'hA3;  4'hD: r = 8'hFD;  4'hE: r = 8'h1F;  4'hF: r = 8'h41;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] crc_hi_nib(input logic [3:0] n);
      logic [7:0] r;
      case (n)
         4'h0: r = 8'h00;  4'h1: r = 8'h9D;  4'h2: r = 8'h23;  4'h3: r = 8'hBE;
         4'h4: r = 8'h46;  4'h5: r = 8'hDB;  4'h6: r = 8'h65;  4'h7: r = 8'hF8;
         4'h8: r = 8'h8C;  4'h9: r = 8'h11;  4'hA: r = 8'hAF;  4'hB: r = 8'h32;
         4'hC: r = 8'hCA;  4'hD: r = 8'h57;  4'hE: r = 8'hE9;  4'hF: r = 8'h74;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // One byte of the reflected 0x8C CRC-8 by two nibble lookups
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] x;
      x = crc ^ b;
      return crc_lo_nib(x[3:0]) ^ crc_hi_nib(x[7:4]);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/one_wire_temp_sensor_sequencer.sv @@
// Top level: byte-level command sequencer for one 1-wire temperature sensor.
`default_nettype none

// Drives an external bit-level bus engine through two jobs. A ROM check
// (request operation 0) issues reset, wait, 0x33, wait, then eight reads and
// reports the 64-bit ROM code when the CRC-8 of bytes 0..6 matches byte 7.
// A temperature read (operation 1) issues reset, 0xCC, 0x44, the conversion
// wait, a second reset, 0xCC, 0xBE, then nine reads, and reports a signed
// 12-bit temperature in 1/16 degree when the CRC-8 of bytes 0..7 matches
// byte 8. Every response beat (operation 2) to the outstanding command yields
// exactly one result beat: the next command or the final report. A missing
// presence pulse ends the job with status "no device", a CRC mismatch with
// status "CRC error". A start while a job runs drops it and starts over.
// Timing: one request beat per clock while req_stall is low. The whole step
// (phase decode, one CRC byte update by two nibble lookups, result build)
// sits between the state registers and the result or skid register. A result
// register plus one skid entry let the block keep taking beats while a result
// waits; req_stall rises only when both are full. The wait lengths come from
// three APB registers, which the user must write only while idle; the block
// does not enforce this. There is no clearing pass after reset.
module one_wire_temp_sensor_sequencer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_operation,
   input  wire logic                          req_present,
   input  wire logic [7:0]                    req_data_byte,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_kind,
   output logic [7:0]                         rsp_write_data,
   output logic [11:0]                        rsp_wait_ms,
   output logic [1:0]                         rsp_status,
   output logic signed [11:0]                 rsp_temperature,
   output logic [63:0]                        rsp_rom_code,
   // configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [owts_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [owts_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [owts_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import owts_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_ROM_RST, PH_ROM_W1, PH_ROM_CMD, PH_ROM_W2,
      PH_T_RST1, PH_T_W1, PH_T_SKIP1, PH_T_W2, PH_T_CONV, PH_T_W3,
      PH_T_RST2, PH_T_W4, PH_T_SKIP2, PH_T_W5, PH_T_RDCMD, PH_T_W6,
      PH_READ
   } phase_type;

   // configuration
   logic [9:0]  settle_wait_ff;
   logic [9:0]  short_wait_ff;
   logic [11:0] conv_wait_ff;
   logic        csr_write;

   // sequencer state
   phase_type   phase_ff, phase_in;
   logic        job_temp_ff, job_temp_in;
   logic [3:0]  count_ff, count_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  bytes_ff [STORED_BYTES];
   logic        byte_we;

   // result register and skid entry
   logic        out_valid_ff, skid_valid_ff;
   rsp_type     out_ff, skid_ff;

   logic        req_accept;
   logic        has_rsp;
   rsp_type     rsp_new;
   logic [3:0]  total_bytes;
   logic        last_byte;
   logic [63:0] rom_word;
   logic [11:0] settle_wait_12;
   logic [11:0] short_wait_12;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_wait_ff <= SETTLE_WAIT_RESET;
         short_wait_ff  <= SHORT_WAIT_RESET;
         conv_wait_ff   <= CONV_WAIT_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_SETTLE_WAIT: settle_wait_ff <= csr_pwdata[9:0];
            REG_SHORT_WAIT:  short_wait_ff  <= csr_pwdata[9:0];
            REG_CONV_WAIT:   conv_wait_ff   <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SETTLE_WAIT: csr_prdata = {{(CSR_DATA_W-10){1'b0}}, settle_wait_ff};
         REG_SHORT_WAIT:  csr_prdata = {{(CSR_DATA_W-10){1'b0}}, short_wait_ff};
         REG_CONV_WAIT:   csr_prdata = {{(CSR_DATA_W-12){1'b0}}, conv_wait_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- step logic ----------------
   // Hold the input only while both result slots are taken.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;

   assign settle_wait_12 = {2'b00, settle_wait_ff};
   assign short_wait_12  = {2'b00, short_wait_ff};

   assign total_bytes = job_temp_ff ? TEMP_BYTES : ROM_BYTES;
   assign last_byte   = ({1'b0, count_ff} + 5'd1) >= {1'b0, total_bytes};

   // ROM code: stored bytes 0..6, byte 7 straight from the bus beat
   always_comb begin
      rom_word = '0;
      for (int i = 0; i < STORED_BYTES; i++) begin
         rom_word[8*i +: 8] = bytes_ff[i];
      end
      rom_word[8*STORED_BYTES +: 8] = req_data_byte;
   end

   always_comb begin
      phase_in    = phase_ff;
      job_temp_in = job_temp_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      has_rsp     = 1'b0;
      rsp_new     = '0;
      byte_we     = 1'b0;
      if (req_accept) begin
         if (req_operation == OP_ROM_CHECK || req_operation == OP_TEMP_READ) begin
            // start or restart a job with a bus reset
            job_temp_in  = (req_operation == OP_TEMP_READ);
            phase_in     = (req_operation == OP_TEMP_READ) ? PH_T_RST1 : PH_ROM_RST;
            count_in     = '0;
            crc_in       = '0;
            has_rsp      = 1'b1;
            rsp_new.kind = KIND_RESET;
         end else if (req_operation == OP_RESPONSE && phase_ff != PH_IDLE) begin
            has_rsp = 1'b1;
            case (phase_ff)
               PH_ROM_RST, PH_T_RST1, PH_T_RST2: begin
                  if (!req_present) begin
                     phase_in       = PH_IDLE;
                     rsp_new.kind   = KIND_REPORT;
                     rsp_new.status = STATUS_NODEV;
                  end else begin
                     phase_in        = (phase_ff == PH_ROM_RST) ? PH_ROM_W1 :
                                       (phase_ff == PH_T_RST1)  ? PH_T_W1 : PH_T_W4;
                     rsp_new.kind    = KIND_WAIT;
                     rsp_new.wait_ms = settle_wait_12;
                  end
               end
               PH_ROM_W1: begin
                  phase_in           = PH_ROM_CMD;
                  rsp_new.kind       = KIND_WRITE;
                  rsp_new.write_data = CMD_READ_ROM;
               end
               PH_ROM_CMD, PH_T_RDCMD: begin
                  phase_in        = (phase_ff == PH_ROM_CMD) ? PH_ROM_W2 : PH_T_W6;
                  rsp_new.kind    = KIND_WAIT;
                  rsp_new.wait_ms = settle_wait_12;
               end
               PH_ROM_W2, PH_T_W6: begin
                  phase_in     = PH_READ;
                  count_in     = '0;
                  crc_in       = '0;
                  rsp_new.kind = KIND_READ;
               end
               PH_T_W1, PH_T_W4: begin
                  phase_in           = (phase_ff == PH_T_W1) ? PH_T_SKIP1 : PH_T_SKIP2;
                  rsp_new.kind       = KIND_WRITE;
                  rsp_new.write_data = CMD_SKIP_ROM;
               end
               PH_T_SKIP1, PH_T_SKIP2: begin
                  phase_in        = (phase_ff == PH_T_SKIP1) ? PH_T_W2 : PH_T_W5;
                  rsp_new.kind    = KIND_WAIT;
                  rsp_new.wait_ms = short_wait_12;
               end
               PH_T_W2: begin
                  phase_in           = PH_T_CONV;
                  rsp_new.kind       = KIND_WRITE;
                  rsp_new.write_data = CMD_CONVERT;
               end
               PH_T_CONV: begin
                  phase_in        = PH_T_W3;
                  rsp_new.kind    = KIND_WAIT;
                  rsp_new.wait_ms = conv_wait_ff;
               end
               PH_T_W3: begin
                  phase_in     = PH_T_RST2;
                  rsp_new.kind = KIND_RESET;
               end
               PH_T_W5: begin
                  phase_in           = PH_T_RDCMD;
                  rsp_new.kind       = KIND_WRITE;
                  rsp_new.write_data = CMD_READ_SCRATCH;
               end
               PH_READ: begin
                  byte_we = ({1'b0, count_ff} < 5'(STORED_BYTES));
                  if (!last_byte) begin
                     crc_in       = crc8_step(crc_ff, req_data_byte);
                     count_in     = count_ff + 4'd1;
                     rsp_new.kind = KIND_READ;
                  end else begin
                     phase_in     = PH_IDLE;
                     rsp_new.kind = KIND_REPORT;
                     if (crc_ff != req_data_byte) begin
                        rsp_new.status = STATUS_CRC;
                     end else if (job_temp_ff) begin
                        rsp_new.status      = STATUS_OK;
                        rsp_new.temperature = {bytes_ff[1][3:0], bytes_ff[0]};
                     end else begin
                        rsp_new.status   = STATUS_OK;
                        rsp_new.rom_code = rom_word;
                     end
                  end
               end
               default: begin
                  // unreachable phase: drop back to idle quietly
                  phase_in = PH_IDLE;
                  has_rsp  = 1'b0;
               end
            endcase
         end
      end
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         job_temp_ff <= 1'b0;
         count_ff    <= '0;
         crc_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         job_temp_ff <= job_temp_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
      end
   end

   // Received bytes: written before read within every job, so no reset.
   always_ff @(posedge clock) begin
      if (byte_we) begin
         bytes_ff[count_ff[STORE_IDX_W-1:0]] <= req_data_byte;
      end
   end

   // ---------------- result register and skid ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && rsp_stall) begin
         // park a new result behind the waiting one
         if (has_rsp) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         // advance the parked result
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= has_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp_stall) begin
         if (has_rsp) begin
            skid_ff <= rsp_new;
         end
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (has_rsp) begin
         out_ff <= rsp_new;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = out_ff.kind;
   assign rsp_write_data  = out_ff.write_data;
   assign rsp_wait_ms     = out_ff.wait_ms;
   assign rsp_status      = out_ff.status;
   assign rsp_temperature = out_ff.temperature;
   assign rsp_rom_code    = out_ff.rom_code;

endmodule

`default_nettype wire

@@ rtl/core/owts_checker.sv @@
// Port-level assertions for the 1-wire sensor sequencer, bound to its top level.
`default_nettype none

module owts_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_stall,
   input wire logic [1:0]                      req_operation,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [2:0]                      rsp_kind,
   input wire logic [7:0]                      rsp_write_data,
   input wire logic [11:0]                     rsp_wait_ms,
   input wire logic [1:0]                      rsp_status,
   input wire logic signed [11:0]              rsp_temperature,
   input wire logic [63:0]                     rsp_rom_code
);
   import owts_pkg::*;

   logic req_beat;
   assign req_beat = req_valid && !req_stall;

   // a stalled result holds its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_status)
         && $stable(rsp_write_data) && $stable(rsp_wait_ms)
         && $stable(rsp_rom_code) && $stable(rsp_temperature))
      else $error("stalled result beat changed");

   // reset leaves both result slots empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result slots not empty after reset");

   // a job start with nothing waiting gives a bus reset command next cycle
   a_start_reset: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid
         && (req_operation == OP_ROM_CHECK || req_operation == OP_TEMP_READ)
      |=> rsp_valid && rsp_kind == KIND_RESET)
      else $error("job start did not issue a bus reset");

   // only reports carry status, temperature and ROM code
   a_report_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_REPORT
      |-> rsp_status == STATUS_OK && rsp_temperature == 12'sd0 && rsp_rom_code == 64'd0)
      else $error("command beat carries report fields");

   // an unused operation code produces no result
   a_unused_op: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_valid && req_operation == OP_UNDEFINED |=> !rsp_valid)
      else $error("unused operation produced a result");

endmodule

bind one_wire_temp_sensor_sequencer owts_checker u_owts_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking bench for the 1-wire sensor sequencer: random job traffic against a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import owts_pkg::*;

   // Bytes the sensor scratchpad can hold
   localparam int SCRATCH_BYTES = 9;
   // Cycles to let ignored beats flush through the result register and skid entry
   localparam int DRAIN_CYCLES = 8;
   // Hard stop for a hung run
   localparam int unsigned CYCLE_LIMIT = 150000;

   // Job steps of the sequencer, as the predictor tracks them
   typedef enum logic [4:0] {
      JOB_IDLE,
      ROM_RESET, ROM_SETTLE1, ROM_READ_CMD, ROM_SETTLE2,
      TMP_RESET1, TMP_SETTLE1, TMP_SKIP1, TMP_SHORT1, TMP_CONVERT, TMP_CONV_WAIT,
      TMP_RESET2, TMP_SETTLE2, TMP_SKIP2, TMP_SHORT2, TMP_SCRATCH_CMD, TMP_SETTLE3,
      READING_BYTES
   } seq_phase_type;

   typedef struct packed {
      logic [1:0] op;
      logic       present;
      logic [7:0] data;
   } sensor_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = 2'd0;
   logic        req_present   = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   // result channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_write_data;
   logic [11:0] rsp_wait_ms;
   logic [1:0]  rsp_status;
   logic signed [11:0] rsp_temperature;
   logic [63:0] rsp_rom_code;
   // configuration port
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Request beats waiting to be driven, results waiting to be seen
   sensor_req_type pending_reqs[$];
   rsp_type        expected_cmds[$];

   int          err_count     = 0;
   int          queued_count  = 0;
   int unsigned cycle_count   = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;

   // Predictor copy of the wait registers
   logic [9:0]  cfg_settle = SETTLE_WAIT_RESET;
   logic [9:0]  cfg_short  = SHORT_WAIT_RESET;
   logic [11:0] cfg_conv   = CONV_WAIT_RESET;

   // Predictor copy of the job state
   seq_phase_type seq_phase   = JOB_IDLE;
   logic          seq_is_temp = 1'b0;
   logic [3:0]    seq_count   = 4'd0;
   logic [7:0]    seq_crc     = 8'd0;
   logic [7:0]    seq_bytes [0:SCRATCH_BYTES-1];

   rsp_type        predicted_cmd;
   rsp_type        oldest_cmd;
   sensor_req_type next_req;

   one_wire_temp_sensor_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_present     (req_present),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_write_data  (rsp_write_data),
      .rsp_wait_ms     (rsp_wait_ms),
      .rsp_status      (rsp_status),
      .rsp_temperature (rsp_temperature),
      .rsp_rom_code    (rsp_rom_code),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // 1-wire CRC-8, one bit at a time: reflected polynomial 0x8C, LSB first
   function automatic logic [7:0] dallas_crc8(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) c = (c >> 1) ^ 8'h8C;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic rsp_type bus_cmd(input logic [2:0] kind, input logic [7:0] wdata,
                                       input logic [11:0] wms);
      rsp_type r;
      r = '0;
      r.kind       = kind;
      r.write_data = wdata;
      r.wait_ms    = wms;
      return r;
   endfunction

   // A report always closes the job
   function automatic rsp_type job_report(input logic [1:0] status, input logic [11:0] temp,
                                          input logic [63:0] rom);
      rsp_type r;
      r = '0;
      r.kind        = KIND_REPORT;
      r.status      = status;
      r.temperature = temp;
      r.rom_code    = rom;
      seq_phase     = JOB_IDLE;
      return r;
   endfunction

   // Advance the job by one request beat; returns 1 when the beat yields a result beat
   function automatic bit sequencer_step(input logic [1:0] op, input logic present,
                                         input logic [7:0] data, output rsp_type r);
      logic [63:0] rom;
      logic [3:0]  total;
      bit          made;
      made = 1'b1;
      r = '0;
      // A start drops whatever job runs and opens with a bus reset
      if (op == OP_ROM_CHECK || op == OP_TEMP_READ) begin
         seq_is_temp = (op == OP_TEMP_READ);
         if (seq_is_temp) seq_phase = TMP_RESET1;
         else seq_phase = ROM_RESET;
         seq_count = 4'd0;
         seq_crc   = 8'd0;
         r = bus_cmd(KIND_RESET, 8'h00, 12'd0);
         return 1'b1;
      end
      // Undefined operations and responses with no job running leave the state alone
      if (op != OP_RESPONSE || seq_phase == JOB_IDLE) return 1'b0;

      case (seq_phase)
         ROM_RESET, TMP_RESET1, TMP_RESET2: begin
            if (!present) begin
               r = job_report(STATUS_NODEV, 12'd0, 64'd0);
            end else begin
               if (seq_phase == ROM_RESET) seq_phase = ROM_SETTLE1;
               else if (seq_phase == TMP_RESET1) seq_phase = TMP_SETTLE1;
               else seq_phase = TMP_SETTLE2;
               r = bus_cmd(KIND_WAIT, 8'h00, {2'b00, cfg_settle});
            end
         end
         ROM_SETTLE1: begin
            seq_phase = ROM_READ_CMD;
            r = bus_cmd(KIND_WRITE, CMD_READ_ROM, 12'd0);
         end
         ROM_READ_CMD: begin
            seq_phase = ROM_SETTLE2;
            r = bus_cmd(KIND_WAIT, 8'h00, {2'b00, cfg_settle});
         end
         ROM_SETTLE2, TMP_SETTLE3: begin
            seq_phase = READING_BYTES;
            seq_count = 4'd0;
            seq_crc   = 8'd0;
            r = bus_cmd(KIND_READ, 8'h00, 12'd0);
         end
         TMP_SETTLE1: begin
            seq_phase = TMP_SKIP1;
            r = bus_cmd(KIND_WRITE, CMD_SKIP_ROM, 12'd0);
         end
         TMP_SKIP1: begin
            seq_phase = TMP_SHORT1;
            r = bus_cmd(KIND_WAIT, 8'h00, {2'b00, cfg_short});
         end
         TMP_SHORT1: begin
            seq_phase = TMP_CONVERT;
            r = bus_cmd(KIND_WRITE, CMD_CONVERT, 12'd0);
         end
         TMP_CONVERT: begin
            seq_phase = TMP_CONV_WAIT;
            r = bus_cmd(KIND_WAIT, 8'h00, cfg_conv);
         end
         TMP_CONV_WAIT: begin
            seq_phase = TMP_RESET2;
            r = bus_cmd(KIND_RESET, 8'h00, 12'd0);
         end
         TMP_SETTLE2: begin
            seq_phase = TMP_SKIP2;
            r = bus_cmd(KIND_WRITE, CMD_SKIP_ROM, 12'd0);
         end
         TMP_SKIP2: begin
            seq_phase = TMP_SHORT2;
            r = bus_cmd(KIND_WAIT, 8'h00, {2'b00, cfg_short});
         end
         TMP_SHORT2: begin
            seq_phase = TMP_SCRATCH_CMD;
            r = bus_cmd(KIND_WRITE, CMD_READ_SCRATCH, 12'd0);
         end
         TMP_SCRATCH_CMD: begin
            seq_phase = TMP_SETTLE3;
            r = bus_cmd(KIND_WAIT, 8'h00, {2'b00, cfg_settle});
         end
         READING_BYTES: begin
            total = seq_is_temp ? TEMP_BYTES : ROM_BYTES;
            if (seq_count < SCRATCH_BYTES) seq_bytes[seq_count] = data;
            if (seq_count + 4'd1 < total) begin
               // fold every byte but the last into the CRC
               seq_crc   = dallas_crc8(seq_crc, data);
               seq_count = seq_count + 4'd1;
               r = bus_cmd(KIND_READ, 8'h00, 12'd0);
            end else if (seq_crc != data) begin
               r = job_report(STATUS_CRC, 12'd0, 64'd0);
            end else if (seq_is_temp) begin
               r = job_report(STATUS_OK, {seq_bytes[1][3:0], seq_bytes[0]}, 64'd0);
            end else begin
               rom = 64'd0;
               for (int i = 7; i >= 0; i--) rom = {rom[55:0], seq_bytes[i]};
               r = job_report(STATUS_OK, 12'd0, rom);
            end
         end
         default: begin
            seq_phase = JOB_IDLE;
            made = 1'b0;
         end
      endcase
      return made;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: advance one request beat per accepted handshake
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // a beat goes in at this edge: predict what it makes
         if (req_valid && !req_stall) begin
            if (sequencer_step(req_operation, req_present, req_data_byte, predicted_cmd))
               expected_cmds.push_back(predicted_cmd);
         end
         // hold a stalled beat; otherwise load the next one or go idle
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_valid     <= 1'b1;
               req_operation <= next_req.op;
               req_present   <= next_req.present;
               req_data_byte <= next_req.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result beat with the oldest prediction
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cmds.size() == 0) begin
               $error("kind mismatch: expected no result beat, actual kind %0d", rsp_kind);
               err_count++;
            end else begin
               oldest_cmd = expected_cmds.pop_front();
               check_field("kind", oldest_cmd.kind, rsp_kind);
               check_field("write_data", oldest_cmd.write_data, rsp_write_data);
               check_field("wait_ms", oldest_cmd.wait_ms, rsp_wait_ms);
               check_field("status", oldest_cmd.status, rsp_status);
               check_field("temperature", oldest_cmd.temperature, rsp_temperature);
               check_field("rom_code", oldest_cmd.rom_code, rsp_rom_code);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   function automatic sensor_req_type make_req(input logic [1:0] op, input logic present,
                                               input logic [7:0] data);
      sensor_req_type q;
      q.op      = op;
      q.present = present;
      q.data    = data;
      return q;
   endfunction

   // Response beat whose unused fields carry junk
   function automatic sensor_req_type any_response();
      return make_req(OP_RESPONSE, 1'($urandom_range(1)), 8'($urandom));
   endfunction

   task automatic push_req(input sensor_req_type q);
      pending_reqs.push_back(q);
      if (q.op != OP_UNDEFINED) queued_count++;
   endtask

   // Queue one job as a well-formed beat sequence. nodev_at drops the presence
   // pulse on the first or second bus reset; keep cuts the job short (-1: whole);
   // forced_temp pins the 12-bit reading of a temperature job (-1: random).
   task automatic add_job(input bit temp_job, input bit bad_crc, input int nodev_at,
                          input int keep, input int forced_temp);
      sensor_req_type job[$];
      logic [7:0]  crc;
      logic [7:0]  b;
      logic [11:0] ft;
      int          nbytes;
      ft = forced_temp[11:0];
      job.push_back(make_req(temp_job ? OP_TEMP_READ : OP_ROM_CHECK,
                             1'($urandom_range(1)), 8'($urandom)));
      job.push_back(make_req(OP_RESPONSE, nodev_at != 1, 8'($urandom)));
      if (nodev_at != 1) begin
         if (temp_job) begin
            // skip ROM, convert, conversion wait, then the second reset
            repeat (5) job.push_back(any_response());
            job.push_back(make_req(OP_RESPONSE, nodev_at != 2, 8'($urandom)));
         end
         if (!(temp_job && nodev_at == 2)) begin
            repeat (temp_job ? 5 : 3) job.push_back(any_response());
            nbytes = temp_job ? 9 : 8;
            crc = 8'd0;
            for (int i = 0; i < nbytes - 1; i++) begin
               b = 8'($urandom);
               if (temp_job && forced_temp >= 0 && i == 0) b = ft[7:0];
               if (temp_job && forced_temp >= 0 && i == 1) b = {4'($urandom), ft[11:8]};
               crc = dallas_crc8(crc, b);
               job.push_back(make_req(OP_RESPONSE, 1'($urandom_range(1)), b));
            end
            if (bad_crc) crc = crc ^ 8'($urandom_range(1, 255));
            job.push_back(make_req(OP_RESPONSE, 1'($urandom_range(1)), crc));
         end
      end
      foreach (job[i])
         if (keep < 0 || i < keep) push_req(job[i]);
   endtask

   // Mostly whole jobs with random content; some cut short, some noise
   task automatic add_random_traffic(input int target);
      int start_count;
      int pick;
      bit temp_job;
      start_count = queued_count;
      while (queued_count - start_count < target) begin
         pick = $urandom_range(99);
         temp_job = 1'($urandom_range(1));
         if (pick < 35) begin
            add_job(1'b0, $urandom_range(9) == 0, 0, -1, -1);
         end else if (pick < 68) begin
            add_job(1'b1, $urandom_range(9) == 0, 0, -1, -1);
         end else if (pick < 76) begin
            add_job(temp_job, 1'b0, temp_job ? $urandom_range(1, 2) : 1, -1, -1);
         end else if (pick < 88) begin
            add_job(temp_job, 1'b0, 0, $urandom_range(1, 12), -1);
         end else begin
            repeat ($urandom_range(1, 3))
               push_req(make_req(2'($urandom), 1'($urandom_range(1)), 8'($urandom)));
         end
      end
   endtask

   // Hold until every beat is in and every command is out, then flush;
   // sample after the edge has settled
   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() != 0 || req_valid || expected_cmds.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready
   task automatic csr_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic verify_waits();
      logic [31:0] got;
      csr_access(1'b0, REG_SETTLE_WAIT, 32'd0, got);
      check_field("settle_wait_ms", {54'd0, cfg_settle}, {32'd0, got});
      csr_access(1'b0, REG_SHORT_WAIT, 32'd0, got);
      check_field("short_wait_ms", {54'd0, cfg_short}, {32'd0, got});
      csr_access(1'b0, REG_CONV_WAIT, 32'd0, got);
      check_field("conversion_wait_ms", {52'd0, cfg_conv}, {32'd0, got});
   endtask

   // Write all three wait registers (upper bits are dropped), then read them back
   task automatic program_waits(input logic [31:0] settle, input logic [31:0] short_ms,
                                input logic [31:0] conv);
      logic [31:0] unused;
      csr_access(1'b1, REG_SETTLE_WAIT, settle, unused);
      cfg_settle = settle[9:0];
      csr_access(1'b1, REG_SHORT_WAIT, short_ms, unused);
      cfg_short = short_ms[9:0];
      csr_access(1'b1, REG_CONV_WAIT, conv, unused);
      cfg_conv = conv[11:0];
      verify_waits();
   endtask

   // Run one phase of random traffic, pausing the sender halfway until all is out
   task automatic run_phase(input int send_pct, input int rsp_pct, input int target);
      send_idle_pct = send_pct;
      stall_pct     = rsp_pct;
      add_random_traffic(target / 2);
      wait_drained();
      add_random_traffic(target - target / 2);
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the wait registers
      verify_waits();

      // Directed beats, no idling
      // responses with no job running are dropped, whatever the fields hold
      push_req(make_req(OP_RESPONSE, 1'b1, 8'hFF));
      push_req(make_req(OP_UNDEFINED, 1'b0, 8'h00));
      // ROM check, nobody answers the reset
      push_req(make_req(OP_ROM_CHECK, 1'b1, 8'hFF));
      push_req(make_req(OP_RESPONSE, 1'b0, 8'hFF));
      // temperature read dropped by a ROM check start, which then finds no device
      push_req(make_req(OP_TEMP_READ, 1'b0, 8'h00));
      push_req(make_req(OP_RESPONSE, 1'b1, 8'h00));
      push_req(make_req(OP_RESPONSE, 1'b0, 8'hFF));
      push_req(make_req(OP_ROM_CHECK, 1'b0, 8'h00));
      push_req(make_req(OP_RESPONSE, 1'b0, 8'h00));
      // temperature read with an undefined beat mid-job, device gone at second reset
      push_req(make_req(OP_TEMP_READ, 1'b1, 8'hFF));
      push_req(make_req(OP_RESPONSE, 1'b1, 8'hFF));
      push_req(make_req(OP_UNDEFINED, 1'b1, 8'hFF));
      repeat (5) push_req(any_response());
      push_req(make_req(OP_RESPONSE, 1'b0, 8'h00));
      wait_drained();

      // Zero waits, no idling; pin the temperature extremes and zero
      program_waits(32'd0, 32'd0, 32'd0);
      add_job(1'b1, 1'b0, 0, -1, 12'h7FF);
      add_job(1'b1, 1'b0, 0, -1, 12'h800);
      add_job(1'b1, 1'b0, 0, -1, 0);
      run_phase(0, 0, 90);

      // Longest waits, sender idles
      program_waits(32'd1023, 32'd1023, 32'd4095);
      run_phase(55, 0, 145);

      // Random waits with junk in the upper bits, receiver stalls
      program_waits($urandom, $urandom, $urandom);
      run_phase(0, 55, 145);

      // Random waits, both sides idle
      program_waits($urandom, $urandom, $urandom);
      run_phase(16, 16, 145);

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/owts_pkg.sv
rtl/core/one_wire_temp_sensor_sequencer.sv
rtl/core/owts_checker.sv
tb/tb.sv
